// ===== design/lpht_pkg.sv =====
// ----------------------------------------------------------------------------
// lpht_pkg
// Shared constants, types and helpers for the linear probing hash table.
// ----------------------------------------------------------------------------
`default_nettype none

package lpht_pkg;

  // table geometry
  localparam int unsigned TABLE_SLOTS = 16;
  localparam int unsigned KEY_BYTES   = 8;

  // fixed field widths
  localparam int unsigned KEY_W    = 64;
  localparam int unsigned LEN_W    = 4;
  localparam int unsigned ID_W     = 16;
  localparam int unsigned STATUS_W = 2;

  // derived widths
  localparam int unsigned SLOT_W    = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
  localparam int unsigned CNT_W     = $clog2(TABLE_SLOTS + 1);
  localparam int unsigned MOD_W     = ((SLOT_W > LEN_W) ? SLOT_W : LEN_W) + 1;
  localparam int unsigned MOD_STEPS = (1 << LEN_W) / TABLE_SLOTS;

  // only the low KEY_BYTES bytes of a key take part
  localparam logic [KEY_W-1:0] KEY_MASK = {KEY_W{1'b1}} >> (KEY_W - 8 * KEY_BYTES);

  typedef logic [SLOT_W-1:0] slot_t;
  typedef logic [KEY_W-1:0]  key_t;
  typedef logic [LEN_W-1:0]  len_t;
  typedef logic [ID_W-1:0]   id_t;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_SEARCH = 1'b1
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_INSERTED  = 2'd0,
    ST_FULL      = 2'd1,
    ST_FOUND     = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_e;

  // one stored slot
  typedef struct packed {
    key_t key;
    len_t len;
    id_t  id;
  } entry_t;

  // slot memory request
  typedef struct packed {
    logic   rd_en;
    logic   wr_en;
    slot_t  addr;
    entry_t wdata;
  } mem_req_t;

  // finished result from the probe controller
  typedef struct packed {
    logic    valid;
    status_e status;
    id_t     id;
  } result_t;

  // home slot: key length reduced modulo the table size by repeated subtraction
  function automatic slot_t home_slot(input len_t len);
    logic [MOD_W-1:0] v;
    v = MOD_W'(len);
    for (int unsigned i = 0; i < MOD_STEPS; i++) begin
      if (v >= MOD_W'(TABLE_SLOTS)) begin
        v = v - MOD_W'(TABLE_SLOTS);
      end
    end
    return v[SLOT_W-1:0];
  endfunction

endpackage

`default_nettype wire

// ===== design/lpht_slot_mem.sv =====
// ----------------------------------------------------------------------------
// lpht_slot_mem
// Slot storage: key, length and id per slot, one write and one registered
// read per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module lpht_slot_mem (
  input  wire logic              clk_i,
  input  wire lpht_pkg::mem_req_t req_i,
  output lpht_pkg::entry_t       rdata_o
);

  lpht_pkg::entry_t slot_mem [lpht_pkg::TABLE_SLOTS];
  lpht_pkg::entry_t rdata_q;

  // write port and registered read port
  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      slot_mem[req_i.addr] <= req_i.wdata;
    end
    if (req_i.rd_en) begin
      rdata_q <= slot_mem[req_i.addr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== design/lpht_probe_ctrl.sv =====
// ----------------------------------------------------------------------------
// lpht_probe_ctrl
// Probe sequencer: walks the slots one per cycle, keeps the valid bits and
// the id counter, and compares read-back slots on a search.
// ----------------------------------------------------------------------------
`default_nettype none

module lpht_probe_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output      logic              in_ready_o,
  input  wire logic              op_i,
  input  wire lpht_pkg::key_t    key_text_i,
  input  wire lpht_pkg::len_t    key_length_i,
  output lpht_pkg::mem_req_t     mem_req_o,
  input  wire lpht_pkg::entry_t  mem_rdata_i,
  output lpht_pkg::result_t      res_o,
  input  wire logic              res_ready_i
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_INSERT,
    S_SEARCH,
    S_RESULT
  } state_e;

  state_e                           state_q;
  lpht_pkg::slot_t                  slot_q;
  logic [lpht_pkg::CNT_W-1:0]       cnt_q;
  logic [lpht_pkg::TABLE_SLOTS-1:0] valid_q;
  lpht_pkg::id_t                    next_id_q;
  logic                             cmp_live_q;
  logic                             cmp_vld_q;
  logic                             cmp_last_q;
  lpht_pkg::status_e                res_status_q;
  lpht_pkg::id_t                    res_id_q;

  lpht_pkg::key_t                   key_q;
  lpht_pkg::len_t                   len_q;
  lpht_pkg::id_t                    fresh_id_q;

  lpht_pkg::slot_t                  slot_next;
  logic                             last_probe;
  logic                             iss_done;
  logic                             hit;

  // probe bookkeeping
  assign slot_next  = (slot_q == lpht_pkg::SLOT_W'(lpht_pkg::TABLE_SLOTS - 1)) ?
                      '0 : slot_q + lpht_pkg::SLOT_W'(1);
  assign last_probe = (cnt_q == lpht_pkg::CNT_W'(lpht_pkg::TABLE_SLOTS - 1));
  assign iss_done   = (cnt_q == lpht_pkg::CNT_W'(lpht_pkg::TABLE_SLOTS));

  // compare of the slot read in the previous cycle, empty slots never match
  assign hit = cmp_live_q && cmp_vld_q &&
               (mem_rdata_i.key == key_q) && (mem_rdata_i.len == len_q);

  assign in_ready_o = (state_q == S_IDLE);

  // memory requests: reads only while searching, writes only while inserting,
  // so a read never meets a write to the same slot
  always_comb begin
    mem_req_o.rd_en       = (state_q == S_SEARCH) && !iss_done;
    mem_req_o.wr_en       = (state_q == S_INSERT) && !valid_q[slot_q];
    mem_req_o.addr        = slot_q;
    mem_req_o.wdata.key   = key_q;
    mem_req_o.wdata.len   = len_q;
    mem_req_o.wdata.id    = fresh_id_q;
  end

  assign res_o.valid  = (state_q == S_RESULT);
  assign res_o.status = res_status_q;
  assign res_o.id     = res_id_q;

  // request payload captured on transfer
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      key_q      <= key_text_i & lpht_pkg::KEY_MASK;
      len_q      <= key_length_i;
      fresh_id_q <= next_id_q;
    end
  end

  // probe state machine
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      slot_q       <= '0;
      cnt_q        <= '0;
      valid_q      <= '0;
      next_id_q    <= lpht_pkg::ID_W'(1);
      cmp_live_q   <= 1'b0;
      cmp_vld_q    <= 1'b0;
      cmp_last_q   <= 1'b0;
      res_status_q <= lpht_pkg::ST_INSERTED;
      res_id_q     <= '0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            slot_q     <= lpht_pkg::home_slot(key_length_i);
            cnt_q      <= '0;
            cmp_live_q <= 1'b0;
            if (op_i == lpht_pkg::OP_INSERT) begin
              next_id_q <= next_id_q + lpht_pkg::ID_W'(1);
              state_q   <= S_INSERT;
            end else begin
              state_q   <= S_SEARCH;
            end
          end
        end
        S_INSERT: begin
          if (!valid_q[slot_q]) begin
            valid_q[slot_q] <= 1'b1;
            res_status_q    <= lpht_pkg::ST_INSERTED;
            res_id_q        <= fresh_id_q;
            state_q         <= S_RESULT;
          end else if (last_probe) begin
            res_status_q <= lpht_pkg::ST_FULL;
            res_id_q     <= '0;
            state_q      <= S_RESULT;
          end else begin
            slot_q <= slot_next;
            cnt_q  <= cnt_q + lpht_pkg::CNT_W'(1);
          end
        end
        S_SEARCH: begin
          // issue the next read while comparing the previous one
          cmp_live_q <= !iss_done;
          cmp_vld_q  <= valid_q[slot_q];
          cmp_last_q <= last_probe;
          if (!iss_done) begin
            slot_q <= slot_next;
            cnt_q  <= cnt_q + lpht_pkg::CNT_W'(1);
          end
          if (hit) begin
            res_status_q <= lpht_pkg::ST_FOUND;
            res_id_q     <= mem_rdata_i.id;
            state_q      <= S_RESULT;
          end else if (cmp_live_q && cmp_last_q) begin
            res_status_q <= lpht_pkg::ST_NOT_FOUND;
            res_id_q     <= '0;
            state_q      <= S_RESULT;
          end
        end
        S_RESULT: begin
          if (res_ready_i) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== design/linear_probe_hash_table_unit.sv =====
// ----------------------------------------------------------------------------
// linear_probe_hash_table_unit
// Open-addressing hash table with linear probing: insert with a fresh id or
// search by key and length, one slot probed per cycle.
// ----------------------------------------------------------------------------
// Probing: an insert first passes k occupied slots (0 .. TABLE_SLOTS-1) and
//   takes the next free one; on a full table it probes all TABLE_SLOTS slots.
//   A search reads slots until a match or until all TABLE_SLOTS are read.
// Throughput: one item at a time; the next input transfer is taken once the
//   result has left the sequencer, one probe per cycle, up to TABLE_SLOTS probes.
// Reset clears all valid bits at once and sets the id counter to one; no
//   clearing pass.
`default_nettype none

module linear_probe_hash_table_unit (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output      logic                          in_ready_o,
  input  wire logic                          op_i,
  input  wire logic [lpht_pkg::KEY_W-1:0]    key_text_i,
  input  wire logic [lpht_pkg::LEN_W-1:0]    key_length_i,
  output      logic                          out_valid_o,
  input  wire logic                          out_ready_i,
  output      logic [lpht_pkg::STATUS_W-1:0] status_o,
  output      logic [lpht_pkg::ID_W-1:0]     entry_id_o
);

  lpht_pkg::mem_req_t mem_req;
  lpht_pkg::entry_t   mem_rdata;
  lpht_pkg::result_t  res;
  logic               res_ready;

  logic               out_valid_q;
  lpht_pkg::status_e  status_q;
  lpht_pkg::id_t      id_q;

  // probe sequencer
  lpht_probe_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .op_i         (op_i),
    .key_text_i   (key_text_i),
    .key_length_i (key_length_i),
    .mem_req_o    (mem_req),
    .mem_rdata_i  (mem_rdata),
    .res_o        (res),
    .res_ready_i  (res_ready)
  );

  // slot storage
  lpht_slot_mem u_mem (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (mem_rdata)
  );

  // output register, free when empty or being drained
  assign res_ready = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res.valid) begin
      status_q <= res.status;
      id_q     <= res.id;
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign entry_id_o  = id_q;

  // no new transfer while a result is still held in the sequencer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |-> !res.valid)
    else $error("input transfer while result pending");

  // read and write of the slot memory never coincide
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mem_req.rd_en && mem_req.wr_en))
    else $error("slot memory read and write in the same cycle");

  // a handed-over result shows up at the output next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res.valid && res_ready) |=> out_valid_o)
    else $error("result lost on the way to the output register");

  // full and not found carry a zero id
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o == lpht_pkg::ST_FULL || status_o == lpht_pkg::ST_NOT_FOUND))
      |-> (entry_id_o == '0))
    else $error("nonzero id with full or not found status");

endmodule

`default_nettype wire
